>>> rtl/i2cbs_pkg.sv
// ----------------------------------------------------------------------------
// i2cbs_pkg
// Shared types, command codes and slot tables for the I2C bit sequencer.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

   // Command codes on the request channel. Code zero is a tick on the command
   // field and means "no operation" in the active operation register.
   // Code seven carries no meaning and has no member.
   typedef enum logic [2:0] {
      OP_IDLE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_SEND  = 3'd3,
      OP_RECV  = 3'd4,
      OP_SACK  = 3'd5,
      OP_RACK  = 3'd6
   } op_type;

   localparam logic [7:0] BYTE_MSB      = 8'h80;
   localparam int         BITS_PER_BYTE = 8;

   // send: data, SCL high, SCL low per bit; receive adds one SDA release slot
   localparam logic [4:0] SEND_SLOTS = 5'(3 * BITS_PER_BYTE);
   localparam logic [4:0] RECV_SLOTS = 5'(3 * BITS_PER_BYTE + 1);

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] tx_value;
      logic       sda_in;
   } req_item_type;

   // Input register to slot engine
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } req_stage_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_in;
      logic       rejected;
   } rsp_item_type;

   function automatic logic [4:0] slot_total(input op_type op);
      logic [4:0] total;
      total = 5'd0;
      case (op)
         OP_START: total = 5'd4;
         OP_STOP:  total = 5'd3;
         OP_SEND:  total = SEND_SLOTS;
         OP_RECV:  total = RECV_SLOTS;
         OP_SACK:  total = 5'd3;
         OP_RACK:  total = 5'd4;
         default:  total = 5'd0;
      endcase
      return total;
   endfunction

endpackage

>>> rtl/i2cbs_ifaces.sv
// ----------------------------------------------------------------------------
// i2cbs channel interfaces
// Valid/ready channels for requests and responses of the I2C bit sequencer.
// ----------------------------------------------------------------------------
interface i2cbs_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [7:0] tx_value;
   logic       sda_in;

   modport source (output valid, command, tx_value, sda_in, input ready);
   modport sink   (input valid, command, tx_value, sda_in, output ready);
endinterface

interface i2cbs_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       ack_in;
   logic       rejected;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_in,
                   rejected, input ready);
   modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_in,
                   rejected, output ready);
endinterface

>>> rtl/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master bit-level sequencer: commands load an operation, ticks step it.
// ----------------------------------------------------------------------------
// Path: a request goes through the input register, then through the slot logic
//   into the response register, which drives the response transaction.
// Throughput: one transaction per cycle; the slot logic is a single pass
//   between two registers, stalled only by a held response.
// Reset: synchronous, active high; SCL and SDA released, sequencer idle,
//   received byte and ack sample cleared.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
   input  logic         clock,
   input  logic         reset,
   i2cbs_req_if.sink    req_bus,
   i2cbs_rsp_if.source  rsp_bus
);

   // Input register hands one transaction a cycle to the slot engine while the engine is ready.
   i2cbs_pkg::req_stage_type stage;
   logic                     stage_ready;

   i2cbs_req_stage u_req_stage (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .downstream_ready (stage_ready),
      .stage            (stage)
   );

   // Slot engine: keeps the bus levels and operation progress, performs one
   // slot per tick, rejects commands while busy, and holds the response
   // until the sink takes it. Code seven is dropped without a slot.
   i2cbs_slot_engine u_slot_engine (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .stage_ready (stage_ready),
      .rsp_bus     (rsp_bus)
   );

endmodule

>>> rtl/i2cbs_req_stage.sv
// ----------------------------------------------------------------------------
// i2cbs_req_stage
// Input register: captures one request transaction per cycle while empty or drained downstream.
// ----------------------------------------------------------------------------
module i2cbs_req_stage (
   input  logic                     clock,
   input  logic                     reset,
   i2cbs_req_if.sink                req_bus,
   input  logic                     downstream_ready,
   output i2cbs_pkg::req_stage_type stage
);

   logic                    valid_ff;
   logic                    valid_in;
   i2cbs_pkg::req_item_type item_ff;
   logic                    take;

   assign take          = !valid_ff || downstream_ready;
   assign req_bus.ready = take;
   assign valid_in      = take ? req_bus.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_bus.valid) begin
         item_ff <= '{command: req_bus.command, tx_value: req_bus.tx_value,
                      sda_in: req_bus.sda_in};
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

>>> rtl/i2cbs_slot_engine.sv
// ----------------------------------------------------------------------------
// i2cbs_slot_engine
// Bus state, one timing slot per tick, and the response register.
// ----------------------------------------------------------------------------
module i2cbs_slot_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  i2cbs_pkg::req_stage_type stage,
   output logic                     stage_ready,
   i2cbs_rsp_if.source              rsp_bus
);

   // bus and sequencing state
   logic                  scl_ff, scl_in;
   logic                  sda_ff, sda_in;
   i2cbs_pkg::op_type     op_ff, op_in;
   logic [4:0]            count_ff, count_in;
   logic [1:0]            phase_ff, phase_in;   // slot position within a bit
   logic [7:0]            shift_ff, shift_in;
   logic [7:0]            rxbyte_ff, rxbyte_in;
   logic                  ack_ff, ack_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   i2cbs_pkg::rsp_item_type  rsp_ff, rsp_in;

   logic                  take;
   logic                  fire;
   logic                  busy;
   logic                  done;
   logic                  rej;
   logic [4:0]            count_plus;
   i2cbs_pkg::op_type     cmd;

   assign take        = !rsp_valid_ff || rsp_bus.ready;
   assign stage_ready = take;
   assign fire        = stage.valid && take;
   assign busy        = (op_ff != i2cbs_pkg::OP_IDLE);
   assign cmd         = i2cbs_pkg::op_type'(stage.item.command);
   assign count_plus  = count_ff + 5'd1;

   always_comb begin
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      op_in     = op_ff;
      count_in  = count_ff;
      phase_in  = phase_ff;
      shift_in  = shift_ff;
      rxbyte_in = rxbyte_ff;
      ack_in    = ack_ff;
      done      = 1'b0;
      rej       = 1'b0;

      if (cmd == i2cbs_pkg::OP_IDLE) begin
         if (busy) begin
            unique case (op_ff)
               i2cbs_pkg::OP_START: begin
                  case (count_ff)
                     5'd0:    sda_in = 1'b1;
                     5'd1:    scl_in = 1'b1;
                     5'd2:    sda_in = 1'b0;
                     default: scl_in = 1'b0;
                  endcase
               end
               i2cbs_pkg::OP_STOP: begin
                  case (count_ff)
                     5'd0:    sda_in = 1'b0;
                     5'd1:    scl_in = 1'b1;
                     default: sda_in = 1'b1;
                  endcase
               end
               i2cbs_pkg::OP_SEND: begin
                  case (phase_ff)
                     2'd0:    sda_in = |(shift_ff & i2cbs_pkg::BYTE_MSB);
                     2'd1:    scl_in = 1'b1;
                     default: begin
                        scl_in   = 1'b0;
                        shift_in = {shift_ff[6:0], 1'b0};
                     end
                  endcase
               end
               i2cbs_pkg::OP_RECV: begin
                  if (count_ff == 5'd0) begin
                     sda_in   = 1'b1;
                     shift_in = 8'd0;
                  end else begin
                     case (phase_ff)
                        2'd0:    scl_in = 1'b1;
                        2'd1:    shift_in = {shift_ff[6:0], stage.item.sda_in};
                        default: scl_in = 1'b0;
                     endcase
                  end
               end
               i2cbs_pkg::OP_SACK: begin
                  case (count_ff)
                     5'd0:    sda_in = |shift_ff;
                     5'd1:    scl_in = 1'b1;
                     default: scl_in = 1'b0;
                  endcase
               end
               i2cbs_pkg::OP_RACK: begin
                  case (count_ff)
                     5'd0:    sda_in = 1'b1;
                     5'd1:    scl_in = 1'b1;
                     5'd2:    ack_in = stage.item.sda_in;
                     default: scl_in = 1'b0;
                  endcase
               end
               default: ;
            endcase

            // bit phase runs mod 3; receive holds it over its release slot
            if ((op_ff == i2cbs_pkg::OP_SEND) ||
                ((op_ff == i2cbs_pkg::OP_RECV) && (count_ff != 5'd0))) begin
               phase_in = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
            end

            if (count_plus >= i2cbs_pkg::slot_total(op_ff)) begin
               if (op_ff == i2cbs_pkg::OP_RECV) begin
                  rxbyte_in = shift_in;
               end
               op_in    = i2cbs_pkg::OP_IDLE;
               count_in = 5'd0;
               done     = 1'b1;
            end else begin
               count_in = count_plus;
            end
         end
      end else if (stage.item.command <= i2cbs_pkg::OP_RACK) begin
         if (busy) begin
            rej = 1'b1;
         end else begin
            op_in    = cmd;
            count_in = 5'd0;
            phase_in = 2'd0;
            shift_in = stage.item.tx_value;
         end
      end
   end

   assign rsp_in = '{scl_out:  scl_in,
                     sda_out:  sda_in,
                     busy_res: (op_in != i2cbs_pkg::OP_IDLE),
                     done_res: done,
                     rx_byte:  rxbyte_in,
                     ack_in:   ack_in,
                     rejected: rej};

   assign rsp_valid_in = take ? stage.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         op_ff        <= i2cbs_pkg::OP_IDLE;
         count_ff     <= 5'd0;
         phase_ff     <= 2'd0;
         shift_ff     <= 8'd0;
         rxbyte_ff    <= 8'd0;
         ack_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            scl_ff    <= scl_in;
            sda_ff    <= sda_in;
            op_ff     <= op_in;
            count_ff  <= count_in;
            phase_ff  <= phase_in;
            shift_ff  <= shift_in;
            rxbyte_ff <= rxbyte_in;
            ack_ff    <= ack_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.scl_out  = rsp_ff.scl_out;
   assign rsp_bus.sda_out  = rsp_ff.sda_out;
   assign rsp_bus.busy_res = rsp_ff.busy_res;
   assign rsp_bus.done_res = rsp_ff.done_res;
   assign rsp_bus.rx_byte  = rsp_ff.rx_byte;
   assign rsp_bus.ack_in   = rsp_ff.ack_in;
   assign rsp_bus.rejected = rsp_ff.rejected;

   // idle sequencer always sits at slot zero
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      (op_ff == i2cbs_pkg::OP_IDLE) |-> (count_ff == 5'd0))
      else $error("slot counter nonzero while idle");

   // slot counter never reaches the operation's length
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (op_ff != i2cbs_pkg::OP_IDLE) |-> (count_ff < i2cbs_pkg::slot_total(op_ff)))
      else $error("slot counter beyond operation length");

   // a finishing slot leaves the sequencer idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (fire && done) |=> (op_ff == i2cbs_pkg::OP_IDLE))
      else $error("operation still active after done");

   // a transaction is never both finished and rejected
   a_done_rej: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.done_res && rsp_ff.rejected))
      else $error("done and rejected together");

   // bit phase stays in its mod-3 range
   a_phase: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("bit phase out of range");

endmodule
